// ----- hdl/indexed_insert_remove_array_defines.svh -----
// Assertion helpers for the indexed insert/remove array.
// Each check is compiled away when SYNTHESIS is defined.
`ifndef INDEXED_INSERT_REMOVE_ARRAY_DEFINES_SVH
`define INDEXED_INSERT_REMOVE_ARRAY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IIRA_ASSERT_NOW(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("check failed");

// next-cycle implication
`define IIRA_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("check failed");

`else

`define IIRA_ASSERT_NOW(label, clk, rst_n, cond, prop)
`define IIRA_ASSERT_NEXT(label, clk, rst_n, cond, prop)

`endif

`endif

// ----- hdl/iira_pkg.sv -----
package iira_pkg;

	localparam int DEPTH_DEFAULT = 256;

	localparam int WORD_W    = 32;
	localparam int OP_W      = 3;
	localparam int POS_W     = 9;
	localparam int ST_W      = 2;
	localparam int CUR_LEN_W = 9;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 48;

	// read tree fan-in per registered level
	localparam int TREE_RADIX = 16;

	localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
	localparam logic [OP_W-1:0] OP_FILL     = 3'd1;
	localparam logic [OP_W-1:0] OP_GET      = 3'd2;
	localparam logic [OP_W-1:0] OP_SET      = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT   = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd5;
	localparam logic [OP_W-1:0] OP_MULTIPLY = 3'd6;

	localparam logic [ST_W-1:0] ST_OK         = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_INDEX  = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL       = 2'd2;
	localparam logic [ST_W-1:0] ST_BAD_LENGTH = 2'd3;

	localparam logic [WORD_W-1:0] WORD_MINUS_ONE = '1;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_FILL,
		ACT_SET,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_MUL
	} act_t;

	// broadcast to every cell
	typedef struct packed {
		act_t              act;
		logic [WORD_W-1:0] operand;
	} cell_cmd_t;

endpackage

// ----- hdl/iira_cell.sv -----
module iira_cell #(
	parameter int CMP_W = iira_pkg::POS_W,
	parameter int INDEX = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  iira_pkg::cell_cmd_t         cmd,
	input  logic [CMP_W-1:0]            pos,
	input  logic [CMP_W-1:0]            len,
	input  logic [iira_pkg::WORD_W-1:0] lower,
	input  logic [iira_pkg::WORD_W-1:0] upper,
	output logic [iira_pkg::WORD_W-1:0] value,
	output logic [iira_pkg::WORD_W-1:0] hit_value
);

	localparam logic [CMP_W-1:0] IDX   = CMP_W'(INDEX);
	localparam logic [CMP_W-1:0] IDX_P = CMP_W'(INDEX + 1);

	logic [iira_pkg::WORD_W-1:0] value_q;
	logic [iira_pkg::WORD_W-1:0] prod;
	logic [iira_pkg::WORD_W-1:0] value_d;
	logic                        live;
	logic                        at_pos;

	assign live   = IDX < len;
	assign at_pos = IDX == pos;
	assign prod   = value_q * cmd.operand;

	always_comb begin
		value_d = value_q;
		unique case (cmd.act)
			iira_pkg::ACT_FILL: begin
				if (live) value_d = cmd.operand;
			end
			iira_pkg::ACT_SET: begin
				if (at_pos) value_d = cmd.operand;
			end
			iira_pkg::ACT_INSERT: begin
				if (at_pos) value_d = cmd.operand;
				else if (IDX > pos && IDX <= len) value_d = lower;
			end
			iira_pkg::ACT_REMOVE: begin
				if (IDX >= pos && IDX_P < len) value_d = upper;
			end
			iira_pkg::ACT_MUL: begin
				if (live) value_d = prod;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else begin
			value_q <= value_d;
		end
	end

	assign value     = value_q;
	assign hit_value = at_pos ? value_q : '0;

endmodule

// ----- hdl/iira_read_tree.sv -----
module iira_read_tree #(
	parameter int DEPTH = iira_pkg::DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic [iira_pkg::WORD_W-1:0] leaf [DEPTH],
	output logic [iira_pkg::WORD_W-1:0] rd_value
);

	localparam int R  = iira_pkg::TREE_RADIX;
	localparam int G1 = (DEPTH + R - 1) / R;
	localparam int G2 = (G1 + R - 1) / R;

	logic [iira_pkg::WORD_W-1:0] part1 [G1][R];
	logic [iira_pkg::WORD_W-1:0] part2 [G2][R];
	logic [iira_pkg::WORD_W-1:0] grp_s1 [G1];
	logic [iira_pkg::WORD_W-1:0] grp_s2 [G2];

	// leaves are one-hot masked, so OR acts as the mux
	for (genvar g = 0; g < G1; g++) begin : g_lvl1
		logic [iira_pkg::WORD_W-1:0] acc;
		for (genvar j = 0; j < R; j++) begin : g_in
			if (g * R + j < DEPTH) begin : g_used
				assign part1[g][j] = leaf[g * R + j];
			end else begin : g_pad
				assign part1[g][j] = '0;
			end
		end
		always_comb begin
			acc = '0;
			for (int j = 0; j < R; j++) acc = acc | part1[g][j];
		end
		always_ff @(posedge clk) begin
			grp_s1[g] <= acc;
		end
	end

	for (genvar g = 0; g < G2; g++) begin : g_lvl2
		logic [iira_pkg::WORD_W-1:0] acc;
		for (genvar j = 0; j < R; j++) begin : g_in
			if (g * R + j < G1) begin : g_used
				assign part2[g][j] = grp_s1[g * R + j];
			end else begin : g_pad
				assign part2[g][j] = '0;
			end
		end
		always_comb begin
			acc = '0;
			for (int j = 0; j < R; j++) acc = acc | part2[g][j];
		end
		always_ff @(posedge clk) begin
			grp_s2[g] <= acc;
		end
	end

	always_comb begin
		rd_value = '0;
		for (int g = 0; g < G2; g++) rd_value = rd_value | grp_s2[g];
	end

endmodule

// ----- hdl/indexed_insert_remove_array.sv -----
// Indexed insert/remove array: one operation in, one result out.
// Each op passes through the cell update, the two registered levels of
// the get read tree and the result load; a new op is taken only while
// idle or as the result is loaded, which waits while a result is held.
// Reset (arst_n low, asynchronous): length zero, all entries zero, no
// result pending; the block is ready for input as soon as it is released.
`include "indexed_insert_remove_array_defines.svh"

module indexed_insert_remove_array #(
	parameter int DEPTH = iira_pkg::DEPTH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// op [2:0], position [11:3], operand [43:12], zero [47:44]
	input  logic [iira_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// read_value [31:0], status [33:32], current_length [42:34], zero [47:43]
	output logic [iira_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int LEN_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (LEN_W > iira_pkg::POS_W) ? LEN_W : iira_pkg::POS_W;
	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(DEPTH);
	localparam int W = iira_pkg::WORD_W;

	// ------------------------------------------------------------------
	// input fields
	// ------------------------------------------------------------------
	logic [iira_pkg::OP_W-1:0]  in_op;
	logic [iira_pkg::POS_W-1:0] in_pos;
	logic [W-1:0]               in_operand;

	assign in_op      = s_tdata[2:0];
	assign in_pos     = s_tdata[11:3];
	assign in_operand = s_tdata[43:12];

	// ------------------------------------------------------------------
	// sequencing: busy_q covers one op from transfer to result load.
	// cnt_q 0: cells update, 1..2: read tree levels, 3: result load.
	// ------------------------------------------------------------------
	logic       busy_q;
	logic [1:0] cnt_q;
	logic       accept;
	logic       done;
	logic       m_tvalid_q;

	assign done     = busy_q && (cnt_q == 2'd3) && (!m_tvalid_q || m_tready);
	assign s_tready = !busy_q || done;
	assign accept   = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// decode and checks, against the length before this op
	// ------------------------------------------------------------------
	logic [LEN_W-1:0] len_q;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] len_x;
	logic             idx_ok;

	assign pos_x  = CMP_W'(in_pos);
	assign len_x  = CMP_W'(len_q);
	assign idx_ok = pos_x < len_x;   // also keeps pos below DEPTH

	iira_pkg::act_t              act_d;
	logic [iira_pkg::ST_W-1:0]   st_d;
	logic [W-1:0]                rd_d;
	logic [LEN_W-1:0]            len_d;
	logic                        get_ok_d;

	always_comb begin
		act_d    = iira_pkg::ACT_NONE;
		st_d     = iira_pkg::ST_OK;
		rd_d     = '0;
		len_d    = len_q;
		get_ok_d = 1'b0;
		unique case (in_op)
			iira_pkg::OP_CREATE: begin
				// negative or above capacity is refused
				if (in_operand[W-1] || in_operand > W'(DEPTH)) begin
					st_d = iira_pkg::ST_BAD_LENGTH;
				end else begin
					len_d = in_operand[LEN_W-1:0];
				end
			end
			iira_pkg::OP_FILL: act_d = iira_pkg::ACT_FILL;
			iira_pkg::OP_GET: begin
				if (idx_ok) begin
					get_ok_d = 1'b1;
				end else begin
					st_d = iira_pkg::ST_BAD_INDEX;
					rd_d = iira_pkg::WORD_MINUS_ONE;
				end
			end
			iira_pkg::OP_SET: begin
				if (idx_ok) begin
					act_d = iira_pkg::ACT_SET;
				end else begin
					st_d = iira_pkg::ST_BAD_INDEX;
					rd_d = iira_pkg::WORD_MINUS_ONE;
				end
			end
			iira_pkg::OP_INSERT: begin
				// index checked before the full condition
				if (pos_x > len_x) begin
					st_d = iira_pkg::ST_BAD_INDEX;
					rd_d = iira_pkg::WORD_MINUS_ONE;
				end else if (len_q == LEN_FULL) begin
					st_d = iira_pkg::ST_FULL;
				end else begin
					act_d = iira_pkg::ACT_INSERT;
					len_d = len_q + LEN_W'(1);
				end
			end
			iira_pkg::OP_REMOVE: begin
				if (idx_ok) begin
					act_d = iira_pkg::ACT_REMOVE;
					len_d = len_q - LEN_W'(1);
				end else begin
					st_d = iira_pkg::ST_BAD_INDEX;
					rd_d = iira_pkg::WORD_MINUS_ONE;
				end
			end
			iira_pkg::OP_MULTIPLY: act_d = iira_pkg::ACT_MUL;
			default: ;   // unused code: no change, status ok
		endcase
	end

	// ------------------------------------------------------------------
	// control and per-op registers
	// ------------------------------------------------------------------
	iira_pkg::act_t            act_q;
	logic [W-1:0]              operand_q;
	logic [CMP_W-1:0]          pos_q;
	logic [CMP_W-1:0]          old_len_q;
	logic [iira_pkg::ST_W-1:0] st_q;
	logic [W-1:0]              rd_q;
	logic                      get_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= 2'd0;
			act_q    <= iira_pkg::ACT_NONE;
			len_q    <= '0;
			get_ok_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q   <= 1'b1;
				cnt_q    <= 2'd0;
				act_q    <= act_d;
				len_q    <= len_d;
				get_ok_q <= get_ok_d;
			end else begin
				// cells act for one cycle only
				act_q <= iira_pkg::ACT_NONE;
				if (done) begin
					busy_q <= 1'b0;
				end else if (busy_q && cnt_q != 2'd3) begin
					cnt_q <= cnt_q + 2'd1;
				end
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			operand_q <= in_operand;
			pos_q     <= pos_x;
			old_len_q <= len_x;
			st_q      <= st_d;
			rd_q      <= rd_d;
		end
	end

	// ------------------------------------------------------------------
	// cell chain: each cell holds one entry and sees its two neighbors
	// ------------------------------------------------------------------
	iira_pkg::cell_cmd_t cmd;
	logic [W-1:0]        vals [DEPTH];
	logic [W-1:0]        hits [DEPTH];

	assign cmd.act     = act_q;
	assign cmd.operand = operand_q;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [W-1:0] lower_v;
		logic [W-1:0] upper_v;
		if (i == 0) begin : g_bottom
			assign lower_v = vals[0];
		end else begin : g_lower
			assign lower_v = vals[i - 1];
		end
		if (i == DEPTH - 1) begin : g_top
			assign upper_v = vals[i];
		end else begin : g_upper
			assign upper_v = vals[i + 1];
		end

		iira_cell #(
			.CMP_W(CMP_W),
			.INDEX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.pos      (pos_q),
			.len      (old_len_q),
			.lower    (lower_v),
			.upper    (upper_v),
			.value    (vals[i]),
			.hit_value(hits[i])
		);
	end

	// ------------------------------------------------------------------
	// get path: masked cell values through a two-level registered tree
	// ------------------------------------------------------------------
	logic [W-1:0] tree_rd;

	iira_read_tree #(
		.DEPTH(DEPTH)
	) u_tree (
		.clk     (clk),
		.leaf    (hits),
		.rd_value(tree_rd)
	);

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	logic [W-1:0]                   out_rd_q;
	logic [iira_pkg::ST_W-1:0]      out_st_q;
	logic [iira_pkg::CUR_LEN_W-1:0] out_len_q;
	logic [CMP_W-1:0]               len_now_x;

	assign len_now_x = CMP_W'(len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_rd_q  <= get_ok_q ? tree_rd : rd_q;
			out_st_q  <= st_q;
			out_len_q <= len_now_x[iira_pkg::CUR_LEN_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;

	always_comb begin
		m_tdata        = '0;
		m_tdata[31:0]  = out_rd_q;
		m_tdata[33:32] = out_st_q;
		m_tdata[42:34] = out_len_q;
	end

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`IIRA_ASSERT_NOW(a_len_bound, clk, arst_n, 1'b1, len_q <= LEN_FULL)
	`IIRA_ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, busy_q && cnt_q == 2'd0)
	`IIRA_ASSERT_NOW(a_act_first_cycle, clk, arst_n, act_q != iira_pkg::ACT_NONE,
		busy_q && cnt_q == 2'd0)
	`IIRA_ASSERT_NEXT(a_done_valid, clk, arst_n, done, m_tvalid_q)

endmodule
